// ----- src/brm_pkg.sv -----
// Shared types and constants for the bisection range mapper.
// No dependencies; imported by brm_step and bisection_range_mapper_top.
`default_nettype none

package brm_pkg;

   // Control bits that travel with each beat down the pipeline
   typedef struct packed {
      logic valid;
      logic done;
   } stage_ctl_type;

   // Configuration register indexes
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INPUT_LOW   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INPUT_HIGH  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_LOW  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_OUTPUT_HIGH = 2'd3;

endpackage

`default_nettype wire

// ----- src/brm_step.sv -----
// One registered halving step of the bisection range mapper pipeline.
// Depends on brm_pkg (stage_ctl_type).
`default_nettype none

module brm_step #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire brm_pkg::stage_ctl_type        ctl_i,
   input  wire logic signed [VALUE_WIDTH-1:0] x_i,
   input  wire logic signed [VALUE_WIDTH-1:0] lo_i,
   input  wire logic signed [VALUE_WIDTH-1:0] hi_i,
   input  wire logic signed [VALUE_WIDTH-1:0] olo_i,
   input  wire logic signed [VALUE_WIDTH-1:0] ohi_i,
   input  wire logic signed [VALUE_WIDTH-1:0] res_i,
   output brm_pkg::stage_ctl_type             ctl_o,
   output logic signed [VALUE_WIDTH-1:0]      x_o,
   output logic signed [VALUE_WIDTH-1:0]      lo_o,
   output logic signed [VALUE_WIDTH-1:0]      hi_o,
   output logic signed [VALUE_WIDTH-1:0]      olo_o,
   output logic signed [VALUE_WIDTH-1:0]      ohi_o,
   output logic signed [VALUE_WIDTH-1:0]      res_o
);
   import brm_pkg::*;

   stage_ctl_type                  ctl_ff, ctl_in;
   logic signed [VALUE_WIDTH-1:0]  x_ff, lo_ff, hi_ff, olo_ff, ohi_ff, res_ff;
   logic signed [VALUE_WIDTH-1:0]  lo_in, hi_in, olo_in, ohi_in, res_in;
   logic signed [VALUE_WIDTH:0]    mid_sum, omid_sum;
   logic signed [VALUE_WIDTH-1:0]  mid, omid;

   // Sum one bit wider, then drop the LSB for a floor midpoint
   assign mid_sum  = {lo_i[VALUE_WIDTH-1], lo_i} + {hi_i[VALUE_WIDTH-1], hi_i};
   assign omid_sum = {olo_i[VALUE_WIDTH-1], olo_i} + {ohi_i[VALUE_WIDTH-1], ohi_i};
   assign mid      = mid_sum[VALUE_WIDTH:1];
   assign omid     = omid_sum[VALUE_WIDTH:1];

   always_comb begin
      ctl_in = ctl_i;
      lo_in  = lo_i;
      hi_in  = hi_i;
      olo_in = olo_i;
      ohi_in = ohi_i;
      res_in = res_i;
      if (!ctl_i.done) begin
         if (x_i >= hi_i) begin
            ctl_in.done = 1'b1;
            res_in      = ohi_i;
         end else if (x_i <= lo_i) begin
            ctl_in.done = 1'b1;
            res_in      = olo_i;
         end else if (olo_i == ohi_i) begin
            ctl_in.done = 1'b1;
            res_in      = olo_i;
         end else if (lo_i == mid) begin
            // range cannot be split any further
            ctl_in.done = 1'b1;
            res_in      = omid;
         end else if (x_i <= mid) begin
            hi_in  = mid;
            ohi_in = omid;
         end else begin
            lo_in  = mid + VALUE_WIDTH'(1);
            olo_in = omid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_i;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      olo_ff <= olo_in;
      ohi_ff <= ohi_in;
      res_ff <= res_in;
   end

   assign ctl_o = ctl_ff;
   assign x_o   = x_ff;
   assign lo_o  = lo_ff;
   assign hi_o  = hi_ff;
   assign olo_o = olo_ff;
   assign ohi_o = ohi_ff;
   assign res_o = res_ff;

endmodule

`default_nettype wire

// ----- src/bisection_range_mapper_top.sv -----
// Top level of the bisection range mapper: CSR bank and halving pipeline.
// Depends on brm_pkg and brm_step.
//
//   channel  | ports                                      | handshake
//   ---------+--------------------------------------------+-------------------------------
//   request  | req_start, busy, req_sample                | beat taken on start && !busy
//   response | rsp_valid, rsp_mapped                      | one-cycle strobe, no backpressure
//   csr      | csr_valid, csr_ready, csr_index, csr_data  | write taken on valid && ready
//
// The pipeline has one brm_step stage per halving step; a new beat may enter
// every cycle while busy is low, so throughput is one beat per cycle.
// busy is high only during reset and the cycle after; csr_ready is always high.
// Reset clears the stage valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

module bisection_range_mapper_top #(
   parameter int VALUE_WIDTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_start,
   output logic                                        busy,
   input  wire logic signed [VALUE_WIDTH-1:0]          req_sample,
   output logic                                        rsp_valid,
   output logic signed [VALUE_WIDTH-1:0]               rsp_mapped,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [brm_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic signed [VALUE_WIDTH-1:0]          csr_data
);
   import brm_pkg::*;

   localparam int NSTAGE     = VALUE_WIDTH + 1;
   localparam int RESET_HIGH = (VALUE_WIDTH > 12) ? 2047 : (2 ** (VALUE_WIDTH - 1)) - 1;

   logic                          busy_ff;
   logic signed [VALUE_WIDTH-1:0] input_low_ff, input_high_ff;
   logic signed [VALUE_WIDTH-1:0] output_low_ff, output_high_ff;

   stage_ctl_type                 ctl_s [NSTAGE+1];
   logic signed [VALUE_WIDTH-1:0] x_s   [NSTAGE+1];
   logic signed [VALUE_WIDTH-1:0] lo_s  [NSTAGE+1];
   logic signed [VALUE_WIDTH-1:0] hi_s  [NSTAGE+1];
   logic signed [VALUE_WIDTH-1:0] olo_s [NSTAGE+1];
   logic signed [VALUE_WIDTH-1:0] ohi_s [NSTAGE+1];
   logic signed [VALUE_WIDTH-1:0] res_s [NSTAGE+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_low_ff   <= '0;
         input_high_ff  <= VALUE_WIDTH'(RESET_HIGH);
         output_low_ff  <= '0;
         output_high_ff <= VALUE_WIDTH'(RESET_HIGH);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INPUT_LOW:   input_low_ff   <= csr_data;
            CSR_INPUT_HIGH:  input_high_ff  <= csr_data;
            CSR_OUTPUT_LOW:  output_low_ff  <= csr_data;
            CSR_OUTPUT_HIGH: output_high_ff <= csr_data;
         endcase
      end
   end

   // Load a new beat with the full configured ranges
   assign ctl_s[0].valid = req_start && !busy_ff;
   assign ctl_s[0].done  = 1'b0;
   assign x_s[0]         = req_sample;
   assign lo_s[0]        = input_low_ff;
   assign hi_s[0]        = input_high_ff;
   assign olo_s[0]       = output_low_ff;
   assign ohi_s[0]       = output_high_ff;
   assign res_s[0]       = output_low_ff;

   for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
      brm_step #(
         .VALUE_WIDTH(VALUE_WIDTH)
      ) u_step (
         .clock (clock),
         .reset (reset),
         .ctl_i (ctl_s[g]),
         .x_i   (x_s[g]),
         .lo_i  (lo_s[g]),
         .hi_i  (hi_s[g]),
         .olo_i (olo_s[g]),
         .ohi_i (ohi_s[g]),
         .res_i (res_s[g]),
         .ctl_o (ctl_s[g+1]),
         .x_o   (x_s[g+1]),
         .lo_o  (lo_s[g+1]),
         .hi_o  (hi_s[g+1]),
         .olo_o (olo_s[g+1]),
         .ohi_o (ohi_s[g+1]),
         .res_o (res_s[g+1])
      );
   end

   assign rsp_valid  = ctl_s[NSTAGE].valid;
   assign rsp_mapped = ctl_s[NSTAGE].done ? res_s[NSTAGE] : olo_s[NSTAGE];

   // Every response must come from a beat accepted at the input and carried through every stage register
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_start && !busy, NSTAGE))
      else $error("response without matching request");

   // The last stage must always have settled the search
   a_settled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ctl_s[NSTAGE].done)
      else $error("bisection not finished at pipeline end");

   // A beat still searching after the first stage must reach the second
   a_first: assert property (@(posedge clock) disable iff (reset)
      ctl_s[1].valid && !ctl_s[1].done |=> ctl_s[2].valid)
      else $error("beat lost between stages");

endmodule

`default_nettype wire
